/* hw/rtl/dfe_pkg.sv */
// Shared types and constants of the delimited frame extractor.
// Depends on nothing; imported by the controller, datapath and top level.
package dfe_pkg;

    localparam logic [1:0] ST_BYTE     = 2'd0;
    localparam logic [1:0] ST_RESTART  = 2'd1;
    localparam logic [1:0] ST_STRAY    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam int REG_BEGIN = 0;
    localparam int REG_END   = 1;

    typedef struct packed {
        logic       restart;
        logic       store;
        logic       close;
        logic       emit;
        logic [1:0] emit_code;
        logic       rd;
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
    } dfe_cmd_t;

    typedef struct packed {
        logic is_begin;
        logic is_end;
        logic frame_open;
        logic full;
        logic idx_last;
        logic out_free;
    } dfe_sts_t;

endpackage

/* hw/rtl/dfe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/dfe_ctrl.sv */
// Controller of the frame extractor: accepts bytes, classifies them, runs readout.
// Depends on dfe_pkg; drives the datapath through dfe_cmd_t.
module dfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dfe_pkg::dfe_sts_t sts,
    output dfe_pkg::dfe_cmd_t cmd
);
    import dfe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_LD   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_begin)
                    begin
                        cmd.restart = 1'b1;
                        if (sts.frame_open)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_code = ST_RESTART;
                        end
                    end
                    else if (!sts.frame_open)
                    begin
                        if (sts.is_end)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_code = ST_STRAY;
                        end
                    end
                    else if (sts.full)
                    begin
                        cmd.close     = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (sts.is_end)
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_LD;
            end
            S_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.close  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_only_in_ld: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_LD))
        else $error("load outside readout");

    a_rd_then_ld: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> (state_reg == S_LD))
        else $error("read not followed by load state");

    a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken during readout");

endmodule

/* hw/rtl/dfe_datapath.sv */
// Datapath of the frame extractor: config registers, fill count, frame store, output register.
// Depends on dfe_pkg and dfe_ram; commanded by dfe_ctrl.
module dfe_datapath #(
    parameter int MAX_FRAME = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dfe_pkg::dfe_cmd_t cmd,
    output dfe_pkg::dfe_sts_t sts,
    input  logic [7:0]        s_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);
    import dfe_pkg::*;

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [7:0]    begin_reg;
    logic [7:0]    end_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [CW-1:0] fill_m1;
    logic          open_reg;
    logic          open_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;
    logic [1:0]    out_status_reg;
    logic          cfg_wr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_q;

    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {24'd0, (paddr[2] ? end_reg : begin_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg <= 8'd2;
            end_reg   <= 8'd3;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_END[0])
            begin
                end_reg <= pwdata[7:0];
            end
            else
            begin
                begin_reg <= pwdata[7:0];
            end
        end
    end

    assign fill_m1 = fill_reg - CW'(1);

    assign sts.is_begin   = (s_tdata == begin_reg);
    assign sts.is_end     = (s_tdata == end_reg);
    assign sts.frame_open = open_reg;
    assign sts.full       = (fill_reg == CW'(MAX_FRAME));
    assign sts.idx_last   = (idx_reg == fill_m1[AW-1:0]);
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        fill_next = fill_reg;
        open_next = open_reg;
        if (cmd.restart)
        begin
            fill_next = CW'(1);
            open_next = 1'b1;
        end
        else if (cmd.store)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (cmd.close)
        begin
            fill_next = '0;
            open_next = 1'b0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            open_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            open_reg <= open_next;
            idx_reg  <= idx_next;
        end
    end

    assign ram_we    = cmd.restart || cmd.store;
    assign ram_waddr = cmd.restart ? '0 : fill_reg[AW-1:0];

    dfe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg   <= 8'd0;
            out_last_reg   <= 1'b1;
            out_status_reg <= cmd.emit_code;
        end
        else if (cmd.load)
        begin
            out_data_reg   <= ram_q;
            out_last_reg   <= sts.idx_last;
            out_status_reg <= ST_BYTE;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_FRAME))
        else $error("fill count beyond store depth");

    a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.load))
        else $error("status and frame byte loaded together");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.load) |-> sts.out_free)
        else $error("output register overwritten before transfer");

    a_store_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (open_reg && !sts.full))
        else $error("store into closed or full frame");

endmodule

/* hw/rtl/delimited_frame_extractor_unit.sv */
// Top level of the delimited frame extractor: controller plus datapath.
// Depends on dfe_pkg, dfe_ctrl, dfe_datapath (and dfe_ram below it).
//
// Channel   Dir  Signals                         Contents
// s_*       in   s_tvalid/s_tready/s_tdata       rx_byte[7:0]
// m_*       out  m_tvalid/m_tready/m_tdata ...   out_byte, out_last, out_status
// apb       in   psel/penable/pwrite/paddr/...   0x0 begin_char, 0x4 end_char
//
// A byte that does not close a frame is handled as it is accepted; a status item is loaded on acceptance.
// A closing byte starts readout of the n-byte frame: each byte is read from the frame store through
// its single registered read port (S_RD), then loaded into the output register once that is free (S_LD).
// s_tready is low during readout and while an unaccepted result blocks the output register.
// rst_n is asynchronous, active low; it closes any frame and restores the delimiters.
// The frame store has no reset; only entries of the current frame are read.
module delimited_frame_extractor_unit #(
    parameter int MAX_FRAME = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] out_status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfe_pkg::*;

    dfe_cmd_t cmd;
    dfe_sts_t sts;

    assign pready = 1'b1;

    dfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dfe_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* sim/delimited_frame_extractor_unit_tb.sv */
// Self-checking testbench for delimited_frame_extractor_unit: directed table, then random
// byte streams over several delimiter settings, checked against an in-bench frame predictor.
// Depends on dfe_pkg and the RTL of delimited_frame_extractor_unit.
`timescale 1ns / 100ps

module delimited_frame_extractor_unit_tb;

    import dfe_pkg::*;

    localparam int FRAME_CAP = 64;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } frame_beat_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic       has_beat;
        logic [1:0] status;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    frame_beat_t expected_beats[$];
    logic [7:0]  cfg_begin = 8'h02;
    logic [7:0]  cfg_end   = 8'h03;
    logic        frame_open = 1'b0;
    logic [7:0]  held [0:FRAME_CAP-1];
    int          held_cnt = 0;
    int          fault_count = 0;
    int          sent_items = 0;
    bit          calm = 1'b0;
    stim_row_t   directed_rows [0:19];

    delimited_frame_extractor_unit #(
        .MAX_FRAME(FRAME_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),      // [7:0] rx_byte
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),      // [7:0] out_byte
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),      // [1:0] out_status
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 clk = ~clk;

    function automatic void note_error(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function automatic void push_status(logic [1:0] code);
        frame_beat_t beat;
        beat = '{data: 8'h00, last: 1'b1, status: code};
        expected_beats.push_back(beat);
    endfunction

    function automatic void frame_predict(logic [7:0] b, bit keep);
        frame_beat_t beat;
        if (b == cfg_begin)
        begin
            if (frame_open && keep)
                push_status(ST_RESTART);
            frame_open = 1'b1;
            held[0] = b;
            held_cnt = 1;
        end
        else if (!frame_open)
        begin
            if (b == cfg_end && keep)
                push_status(ST_STRAY);
        end
        else if (held_cnt >= FRAME_CAP)
        begin
            frame_open = 1'b0;
            held_cnt = 0;
            if (keep)
                push_status(ST_OVERFLOW);
        end
        else
        begin
            held[held_cnt] = b;
            held_cnt++;
            if (b == cfg_end)
            begin
                for (int k = 0; k < held_cnt; k++)
                begin
                    beat = '{data: held[k], last: (k == held_cnt - 1), status: ST_BYTE};
                    if (keep)
                        expected_beats.push_back(beat);
                end
                frame_open = 1'b0;
                held_cnt = 0;
            end
        end
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        v = 8'($urandom);
        while (v == cfg_begin || v == cfg_end)
            v = 8'($urandom);
        return v;
    endfunction

    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
                note_error($sformatf("unexpected transfer byte=%02h last=%b status=%0d",
                                     m_tdata, m_tlast, m_tuser));
            else
            begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.status)
                    note_error($sformatf("exp byte=%02h last=%b status=%0d, got %02h %b %0d",
                                         want.data, want.last, want.status,
                                         m_tdata, m_tlast, m_tuser));
            end
        end
    end

    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);

    task automatic drive_byte(input logic [7:0] b, input bit keep);
        while (!calm && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
        frame_predict(b, keep);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_access(input int idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= {24'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {24'h0, v})
            note_error($sformatf("register %0d read %08h, exp %08h", idx, prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_delimiters(input logic [7:0] b, input logic [7:0] e);
        settle();
        reg_access(REG_BEGIN, b);
        cfg_begin = b;
        reg_access(REG_END, e);
        cfg_end = e;
    endtask

    task automatic send_frame(input int len);
        drive_byte(cfg_begin, 1'b1);
        repeat (len) drive_byte(plain_byte(), 1'b1);
        drive_byte(cfg_end, 1'b1);
    endtask

    task automatic send_overflow(input bit by_end);
        drive_byte(cfg_begin, 1'b1);
        repeat (FRAME_CAP - 1) drive_byte(plain_byte(), 1'b1);
        drive_byte(by_end ? cfg_end : plain_byte(), 1'b1);
        drive_byte(plain_byte(), 1'b1);
        drive_byte(cfg_end, 1'b1);
    endtask

    initial
    begin
        int pick;
        int goal;
        logic [7:0] b;
        logic [7:0] e;

        directed_rows = '{
            '{8'h03, 1'b1, 1'b1, ST_STRAY},
            '{8'h41, 1'b1, 1'b0, ST_BYTE},
            '{8'hFF, 1'b1, 1'b0, ST_BYTE},
            '{8'h00, 1'b1, 1'b0, ST_BYTE},
            '{8'h02, 1'b1, 1'b0, ST_BYTE},
            '{8'h00, 1'b1, 1'b0, ST_BYTE},
            '{8'hFF, 1'b1, 1'b0, ST_BYTE},
            '{8'h02, 1'b1, 1'b1, ST_RESTART},
            '{8'h80, 1'b0, 1'b0, ST_BYTE},
            '{8'h03, 1'b0, 1'b0, ST_BYTE},
            '{8'h02, 1'b1, 1'b0, ST_BYTE},
            '{8'h03, 1'b0, 1'b0, ST_BYTE},
            '{8'h03, 1'b1, 1'b1, ST_STRAY},
            '{8'h02, 1'b1, 1'b0, ST_BYTE},
            '{8'h02, 1'b1, 1'b1, ST_RESTART},
            '{8'h02, 1'b1, 1'b1, ST_RESTART},
            '{8'h7F, 1'b0, 1'b0, ST_BYTE},
            '{8'h00, 1'b0, 1'b0, ST_BYTE},
            '{8'h03, 1'b0, 1'b0, ST_BYTE},
            '{8'h55, 1'b1, 1'b0, ST_BYTE}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            drive_byte(directed_rows[i].rx, !directed_rows[i].typed);
            if (directed_rows[i].typed && directed_rows[i].has_beat)
                push_status(directed_rows[i].status);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin b = 8'h00; e = 8'hFF; end
                1: begin b = 8'hFF; e = 8'h00; end
                2: begin b = 8'h7E; e = 8'h7E; end
                3: begin b = 8'($urandom); e = b ^ 8'($urandom_range(1, 255)); end
                4: begin b = 8'h02; e = 8'h03; end
                default: begin b = 8'($urandom); e = 8'($urandom); end
            endcase
            set_delimiters(b, e);
            calm = (phase == 3);
            goal = sent_items + 45;
            case (phase)
                0: send_frame(FRAME_CAP - 2);
                1: send_overflow(1'b1);
                2: send_overflow(1'b0);
                default: ;
            endcase
            while (sent_items < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 2)
                    send_frame(FRAME_CAP - 2);
                else if (pick < 60)
                    send_frame($urandom_range(0, 8));
                else if (pick < 72)
                    repeat ($urandom_range(1, 5)) drive_byte(8'($urandom), 1'b1);
                else if (pick < 84)
                begin
                    drive_byte(cfg_begin, 1'b1);
                    repeat ($urandom_range(0, 4)) drive_byte(plain_byte(), 1'b1);
                end
                else if (pick < 92)
                    drive_byte(cfg_end, 1'b1);
                else
                    drive_byte(($urandom_range(1) != 0) ? cfg_begin : cfg_end, 1'b1);
            end
        end

        calm = 1'b0;
        settle();
        repeat (12) @(posedge clk);
        if (fault_count == 0 && expected_beats.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
